// ----- design/xnpt_pkg.sv -----
package xnpt_pkg;

	// table geometry
	localparam int TABLE_DEPTH = 64;
	localparam int ID_WIDTH    = 64;
	localparam int CONN_WIDTH  = 16;

	localparam int IDX_W   = $clog2(TABLE_DEPTH);
	localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
	localparam int ENTRY_W = ID_WIDTH + CONN_WIDTH;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

	// fixed port widths
	localparam int ID_PORT_W    = 64;
	localparam int CONN_PORT_W  = 16;
	localparam int SLOT_PORT_W  = 6;
	localparam int COUNT_PORT_W = 7;

	typedef enum logic [2:0] {
		OP_ADD       = 3'd0,
		OP_REM_ID    = 3'd1,
		OP_REM_CONN  = 3'd2,
		OP_FIND_ID   = 3'd3,
		OP_FIND_CONN = 3'd4,
		OP_NEAREST   = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		STS_DONE = 2'd0,
		STS_NONE = 2'd1,
		STS_FULL = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

endpackage

// ----- design/xnpt_ram.sv -----
module xnpt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- design/xor_nearest_peer_table_unit.sv -----
// Peer table with XOR-distance lookup. Pulse start for one cycle while busy
// is low to hand in one operation word (op, peer_id, conn_handle, except_id,
// include_local); busy rises on the next cycle and each operation returns
// exactly one result word, shown on the result ports for a single cycle
// with done high. The receiver cannot stall: capture the result in the cycle
// that done is high. Add, remove, find and nearest walk the slots one per
// cycle through a synchronous entry memory with registered reads, and the
// next start is taken in the cycle that done is shown. Add and find stop
// at the first free slot (add) or first match (find); unused op codes skip
// the walk. local_id is written through cfg_we / cfg_wdata and must only
// be changed while busy is low and no result is pending.
module xor_nearest_peer_table_unit (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// configuration
	input  logic                                   cfg_we,
	input  logic [xnpt_pkg::ID_PORT_W-1:0]         cfg_wdata,
	// command
	input  logic                                   start,
	output logic                                   busy,
	input  logic [2:0]                             op,
	input  logic [xnpt_pkg::ID_PORT_W-1:0]         peer_id,
	input  logic [xnpt_pkg::CONN_PORT_W-1:0]       conn_handle,
	input  logic [xnpt_pkg::ID_PORT_W-1:0]         except_id,
	input  logic                                   include_local,
	// result
	output logic                                   done,
	output xnpt_pkg::status_t                      status,
	output logic                                   is_local,
	output logic [xnpt_pkg::SLOT_PORT_W-1:0]       slot_index,
	output logic [xnpt_pkg::ID_PORT_W-1:0]         found_id,
	output logic [xnpt_pkg::CONN_PORT_W-1:0]       found_conn,
	output logic [xnpt_pkg::COUNT_PORT_W-1:0]      removed_count
);

	import xnpt_pkg::*;

	state_t state_q, state_d;

	// configuration
	logic [ID_WIDTH-1:0] local_id_q;

	// latched command word
	op_t                   op_q;
	logic [ID_WIDTH-1:0]   pid_q;
	logic [CONN_WIDTH-1:0] conn_q;
	logic [ID_WIDTH-1:0]   exc_q;
	logic                  inc_q;
	logic                  op_ok;

	// slot valid bits
	logic [TABLE_DEPTH-1:0] valid_q;

	// read issue and read-return stage
	logic             issuing_q;
	logic [IDX_W-1:0] addr_q;
	logic             vld_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [ENTRY_W-1:0] rd_data;

	// running result of the walk
	logic                  have_q;
	logic [IDX_W-1:0]      best_idx_q;
	logic [ID_WIDTH-1:0]   best_id_q;
	logic [CONN_WIDTH-1:0] best_conn_q;
	logic [ID_WIDTH-1:0]   best_dist_q;
	logic [CNT_W-1:0]      count_q;

	// per-entry decode
	logic                  accept;
	logic                  proc;
	logic                  ent_v;
	logic [ID_WIDTH-1:0]   ent_id;
	logic [CONN_WIDTH-1:0] ent_conn;
	logic [ID_WIDTH-1:0]   ent_dist;
	logic                  take;
	logic                  clear;
	logic                  early;
	logic                  scan_end;
	logic                  ram_we;

	// final result decode
	logic [ID_WIDTH-1:0] local_dist;
	logic                local_wins;
	status_t             res_status;
	logic                res_local;
	logic                res_entry;

	assign accept = start && !busy;

	always_comb begin
		case (op)
			OP_ADD, OP_REM_ID, OP_REM_CONN, OP_FIND_ID, OP_FIND_CONN, OP_NEAREST: op_ok = 1'b1;
			default: op_ok = 1'b0;
		endcase
	end

	xnpt_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_DEPTH)
	) u_entry_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (idx_s1),
		.wdata ({conn_q, pid_q}),
		.re    (issuing_q),
		.raddr (addr_q),
		.rdata (rd_data)
	);

	// Decode the entry returned by the memory this cycle.
	always_comb begin
		ent_id   = rd_data[ID_WIDTH-1:0];
		ent_conn = rd_data[ID_WIDTH +: CONN_WIDTH];
		ent_v    = valid_q[idx_s1];
		ent_dist = pid_q ^ ent_id;
		proc     = vld_s1 && (state_q == ST_SCAN);
		take     = 1'b0;
		clear    = 1'b0;
		early    = 1'b0;
		ram_we   = 1'b0;
		case (op_q)
			OP_ADD: begin
				take   = !ent_v;
				early  = !ent_v;
				ram_we = proc && !ent_v;
			end
			OP_REM_ID: begin
				clear = ent_v && (ent_id == pid_q);
			end
			OP_REM_CONN: begin
				clear = ent_v && (ent_conn == conn_q);
			end
			OP_FIND_ID: begin
				take  = ent_v && (ent_id == pid_q);
				early = take;
			end
			OP_FIND_CONN: begin
				take  = ent_v && (ent_conn == conn_q);
				early = take;
			end
			OP_NEAREST: begin
				// strict less keeps ties on the lowest slot
				take = ent_v && (ent_id != exc_q) && (!have_q || (ent_dist < best_dist_q));
			end
			default: begin
				take = 1'b0;
			end
		endcase
		scan_end = proc && (early || (idx_s1 == LAST_IDX));
	end

	// Decode the final answer from the walk.
	always_comb begin
		local_dist = pid_q ^ local_id_q;
		local_wins = 1'b0;
		res_status = STS_NONE;
		res_local  = 1'b0;
		res_entry  = 1'b0;
		case (op_q)
			OP_ADD: begin
				res_status = have_q ? STS_DONE : STS_FULL;
				res_entry  = have_q;
			end
			OP_REM_ID, OP_REM_CONN: begin
				res_status = (count_q != '0) ? STS_DONE : STS_NONE;
			end
			OP_FIND_ID: begin
				// fall back to the local node on a miss
				res_entry  = have_q;
				res_local  = !have_q && (pid_q == local_id_q);
				res_status = (res_entry || res_local) ? STS_DONE : STS_NONE;
			end
			OP_FIND_CONN: begin
				res_entry  = have_q;
				res_status = have_q ? STS_DONE : STS_NONE;
			end
			OP_NEAREST: begin
				// local node beats the table only on a strictly smaller distance
				local_wins = inc_q && (!have_q || (local_dist < best_dist_q));
				res_local  = local_wins;
				res_entry  = !local_wins && have_q;
				res_status = (res_local || res_entry) ? STS_DONE : STS_NONE;
			end
			default: begin
				res_status = STS_NONE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and busy
	always_comb begin
		state_d = state_q;
		busy    = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					state_d = op_ok ? ST_SCAN : ST_FINISH;
				end
			end
			ST_SCAN: begin
				if (scan_end) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control: config, valid bits, read sequencing, result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_id_q <= '0;
			valid_q    <= '0;
			issuing_q  <= 1'b0;
			vld_s1     <= 1'b0;
			done       <= 1'b0;
		end else begin
			if (cfg_we) begin
				local_id_q <= cfg_wdata[ID_WIDTH-1:0];
			end
			done <= (state_q == ST_FINISH);

			// valid bits change only at the slot being processed
			if (proc && ram_we) begin
				valid_q[idx_s1] <= 1'b1;
			end else if (proc && clear) begin
				valid_q[idx_s1] <= 1'b0;
			end

			if (accept) begin
				issuing_q <= op_ok;
			end else if (scan_end || (issuing_q && (addr_q == LAST_IDX))) begin
				// stop issuing at the last slot or on an early hit
				issuing_q <= 1'b0;
			end
			vld_s1 <= issuing_q && !scan_end;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= op_t'(op);
			pid_q   <= peer_id[ID_WIDTH-1:0];
			conn_q  <= conn_handle[CONN_WIDTH-1:0];
			exc_q   <= except_id[ID_WIDTH-1:0];
			inc_q   <= include_local;
			have_q  <= 1'b0;
			count_q <= '0;
			addr_q  <= '0;
		end else begin
			if (issuing_q && (addr_q != LAST_IDX)) begin
				addr_q <= addr_q + 1'b1;
			end
			if (proc && take) begin
				have_q      <= 1'b1;
				best_idx_q  <= idx_s1;
				best_dist_q <= ent_dist;
				// an add reports the word it stores
				best_id_q   <= (op_q == OP_ADD) ? pid_q : ent_id;
				best_conn_q <= (op_q == OP_ADD) ? conn_q : ent_conn;
			end
			if (proc && clear) begin
				count_q <= count_q + 1'b1;
			end
		end
		idx_s1 <= addr_q;

		// load the result word as the walk closes
		if (state_q == ST_FINISH) begin
			status        <= res_status;
			is_local      <= res_local;
			slot_index    <= res_entry ? SLOT_PORT_W'(best_idx_q) : '0;
			found_id      <= res_entry ? ID_PORT_W'(best_id_q)
				: (res_local ? ID_PORT_W'(local_id_q) : '0);
			found_conn    <= res_entry ? CONN_PORT_W'(best_conn_q) : '0;
			removed_count <= ((op_q == OP_REM_ID) || (op_q == OP_REM_CONN))
				? COUNT_PORT_W'(count_q) : '0;
		end
	end

endmodule
